@@ hw/rtl/clr_pkg.sv @@
// ----------------------------------------------------------------------------
// clr_pkg
// Shared types and constants for the clipped line rasterizer.
// ----------------------------------------------------------------------------
package clr_pkg;

  localparam int COORD_BITS = 16;
  localparam int SPAN_W     = COORD_BITS + 1;
  localparam int ERR_W      = COORD_BITS + 2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [SPAN_W-1:0]     span_t;
  typedef logic signed [ERR_W-1:0]      err_t;

  // Item kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_SCREEN_WIDTH  = 3'd0,
    REG_SCREEN_HEIGHT = 3'd1,
    REG_GAIN_RED      = 3'd2,
    REG_GAIN_GREEN    = 3'd3,
    REG_GAIN_BLUE     = 3'd4
  } cfg_sel_t;

  localparam logic [7:0]  GAIN_FULL     = 8'd255;
  localparam logic [15:0] MASK_SIX_BIT  = 16'b0000000000111111;
  localparam logic [15:0] MASK_FIVE_BIT = 16'b0000000000011111;

  typedef struct packed {
    logic [7:0] screen_width;
    logic [7:0] screen_height;
    logic [7:0] gain_red;
    logic [7:0] gain_green;
    logic [7:0] gain_blue;
  } cfg_t;

  typedef struct packed {
    coord_t cur_x;
    coord_t cur_y;
    coord_t target_x;
    coord_t target_y;
    span_t  span_x;
    span_t  span_y;
    logic   step_x_negative;
    logic   step_y_negative;
    err_t   error_term;
  } line_t;

  typedef struct packed {
    logic        point_active;
    logic        write_enable;
    logic [15:0] pixel_address;
    logic [15:0] pixel_color;
    logic        line_done;
  } result_t;

endpackage

@@ hw/rtl/clipped_line_rasterizer.sv @@
// ----------------------------------------------------------------------------
// clipped_line_rasterizer
// Bresenham line engine with screen clipping and brightness scaling.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): kind = start loads endpoints and
//   color and yields the first point; kind = tick yields the next point.
//   Every transaction gives exactly one result transaction.
//   Output channel (out_valid / out_stall): one result per point with
//   write enable, framebuffer address, scaled color and a last-point flag.
//   A tick with no line running yields an all-zero result.
//   Config channel (cfg_valid / cfg_ready): index 0..4 selects screen width,
//   screen height, red, green, blue gain. Always ready; write only when idle.
// Timing:
//   An input transaction loads the input register; when the held item is
//   processed, the combinational point step loads the result register.
//   Throughput is one item per cycle while out_stall does not hold a full
//   result register.
// Reset: rst (synchronous) empties both registers, drops any running line and
//   restores the register defaults (160 x 128, gains 255).
// Stall: while out_stall holds a full result register, the input register
//   holds its item and in_stall rises, so no transaction is lost.
// ----------------------------------------------------------------------------
module clipped_line_rasterizer import clr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // item input
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               kind,
  input  logic signed [15:0] start_x,
  input  logic signed [15:0] start_y,
  input  logic signed [15:0] end_x,
  input  logic signed [15:0] end_y,
  input  logic        [15:0] line_color,
  // result output
  output logic               out_valid,
  input  logic               out_stall,
  output logic               point_active,
  output logic               write_enable,
  output logic        [15:0] pixel_address,
  output logic        [15:0] pixel_color,
  output logic               line_done,
  // configuration writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic        [2:0]  cfg_index,
  input  logic        [7:0]  cfg_data
);

  cfg_t cfg;

  // Input register
  logic               item_valid;
  logic               item_kind;
  logic signed [15:0] item_start_x, item_start_y, item_end_x, item_end_y;
  logic        [15:0] item_color;

  // Line state
  line_t       line;
  logic        busy;
  logic [15:0] scaled_color;

  // Point logic
  line_t       line_init, line_cur, line_next;
  logic [15:0] color_init, color_cur;
  result_t     res_step, res_next;
  logic        done;
  logic        is_start;
  logic        active;
  logic        fire;

  clr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  clr_setup u_setup (
    .start_x   (item_start_x),
    .start_y   (item_start_y),
    .end_x     (item_end_x),
    .end_y     (item_end_y),
    .line_init (line_init)
  );

  clr_shade u_shade (
    .color_in  (item_color),
    .cfg       (cfg),
    .color_out (color_init)
  );

  clr_advance u_advance (
    .line_cur  (line_cur),
    .cfg       (cfg),
    .color     (color_cur),
    .res       (res_step),
    .line_next (line_next),
    .done      (done)
  );

  // Process the held item whenever the result register is free or draining.
  assign fire     = item_valid && (!out_valid || !out_stall);
  assign in_stall = item_valid && !fire;

  // A start replaces any running line; a tick uses the stored state.
  always_comb begin
    is_start  = (item_kind == KIND_START);
    active    = is_start || busy;
    line_cur  = is_start ? line_init : line;
    color_cur = is_start ? color_init : scaled_color;
    res_next  = active ? res_step : '0;
  end

  // Capture a new item; hold it while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_kind    <= kind;
      item_start_x <= start_x;
      item_start_y <= start_y;
      item_end_x   <= end_x;
      item_end_y   <= end_y;
      item_color   <= line_color;
    end
  end

  // Advance the line; on the end point hold the position and go idle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (fire && active) begin
      busy <= !done;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && active) begin
      line         <= done ? line_cur : line_next;
      scaled_color <= color_cur;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      point_active  <= res_next.point_active;
      write_enable  <= res_next.write_enable;
      pixel_address <= res_next.pixel_address;
      pixel_color   <= res_next.pixel_color;
      line_done     <= res_next.line_done;
    end
  end

endmodule

@@ hw/rtl/clr_cfg.sv @@
// ----------------------------------------------------------------------------
// clr_cfg
// Configuration register file: screen size and brightness gains.
// ----------------------------------------------------------------------------
module clr_cfg import clr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  output cfg_t       cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_width  <= 8'd160;
      cfg.screen_height <= 8'd128;
      cfg.gain_red      <= GAIN_FULL;
      cfg.gain_green    <= GAIN_FULL;
      cfg.gain_blue     <= GAIN_FULL;
    end else if (cfg_valid) begin
      unique case (cfg_sel_t'(cfg_index))
        REG_SCREEN_WIDTH:  cfg.screen_width  <= cfg_data;
        REG_SCREEN_HEIGHT: cfg.screen_height <= cfg_data;
        REG_GAIN_RED:      cfg.gain_red      <= cfg_data;
        REG_GAIN_GREEN:    cfg.gain_green    <= cfg_data;
        REG_GAIN_BLUE:     cfg.gain_blue     <= cfg_data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

endmodule

@@ hw/rtl/clr_shade.sv @@
// ----------------------------------------------------------------------------
// clr_shade
// Per-channel brightness scaling of an RGB565 color.
// ----------------------------------------------------------------------------
module clr_shade import clr_pkg::*; (
  input  logic [15:0] color_in,
  input  cfg_t        cfg,
  output logic [15:0] color_out
);

  logic [4:0]  red;
  logic [5:0]  green;
  logic [4:0]  blue;
  logic [12:0] red_prod;
  logic [13:0] green_prod;
  logic [12:0] blue_prod;
  logic        all_full;

  always_comb begin
    red        = 5'((color_in >> 11) & MASK_FIVE_BIT);
    green      = 6'((color_in >> 5) & MASK_SIX_BIT);
    blue       = 5'(color_in & MASK_FIVE_BIT);
    red_prod   = red * cfg.gain_red;
    green_prod = green * cfg.gain_green;
    blue_prod  = blue * cfg.gain_blue;
    all_full   = (cfg.gain_red == GAIN_FULL) && (cfg.gain_green == GAIN_FULL) &&
                 (cfg.gain_blue == GAIN_FULL);
    if (all_full) begin
      color_out = color_in;
    end else begin
      color_out = {red_prod[12:8], green_prod[13:8], blue_prod[12:8]};
    end
  end

endmodule

@@ hw/rtl/clr_setup.sv @@
// ----------------------------------------------------------------------------
// clr_setup
// Builds the initial line state from two endpoints.
// ----------------------------------------------------------------------------
module clr_setup import clr_pkg::*; (
  input  logic signed [15:0] start_x,
  input  logic signed [15:0] start_y,
  input  logic signed [15:0] end_x,
  input  logic signed [15:0] end_y,
  output line_t              line_init
);

  // Keep the low COORD_BITS of the sign-extended field.
  function automatic coord_t to_coord(input logic signed [15:0] f);
    logic [COORD_BITS+15:0] ext;
    ext = {{COORD_BITS{f[15]}}, f};
    return coord_t'(ext[COORD_BITS-1:0]);
  endfunction

  coord_t                   x1, y1, x2, y2;
  logic signed [SPAN_W-1:0] dx, dy;
  span_t                    sx, sy;

  always_comb begin
    x1 = to_coord(start_x);
    y1 = to_coord(start_y);
    x2 = to_coord(end_x);
    y2 = to_coord(end_y);
    dx = $signed({x2[COORD_BITS-1], x2}) - $signed({x1[COORD_BITS-1], x1});
    dy = $signed({y2[COORD_BITS-1], y2}) - $signed({y1[COORD_BITS-1], y1});
    sx = dx[SPAN_W-1] ? span_t'(-dx) : span_t'(dx);
    sy = dy[SPAN_W-1] ? span_t'(-dy) : span_t'(dy);

    line_init.cur_x           = x1;
    line_init.cur_y           = y1;
    line_init.target_x        = x2;
    line_init.target_y        = y2;
    line_init.span_x          = sx;
    line_init.span_y          = sy;
    line_init.step_x_negative = dx[SPAN_W-1] || (dx == '0);
    line_init.step_y_negative = dy[SPAN_W-1] || (dy == '0);
    // Halve with truncation toward zero: shift the magnitude, then negate.
    if (sx > sy) begin
      line_init.error_term = err_t'({2'b00, sx[SPAN_W-1:1]});
    end else begin
      line_init.error_term = -err_t'({2'b00, sy[SPAN_W-1:1]});
    end
  end

endmodule

@@ hw/rtl/clr_advance.sv @@
// ----------------------------------------------------------------------------
// clr_advance
// Emits the current point (clip, address, color) and the next line state.
// ----------------------------------------------------------------------------
module clr_advance import clr_pkg::*; (
  input  line_t       line_cur,
  input  cfg_t        cfg,
  input  logic [15:0] color,
  output result_t     res,
  output line_t       line_next,
  output logic        done
);

  logic                   on_screen;
  logic [15:0]            row_base;
  logic signed [ERR_W:0]  e_w, sx_w, sy_w, e_n;
  logic                   move_x, move_y;
  coord_t                 inc_x, inc_y;

  always_comb begin
    done   = (line_cur.cur_x == line_cur.target_x) &&
             (line_cur.cur_y == line_cur.target_y);
    on_screen = (line_cur.cur_x[COORD_BITS-1:8] == '0) &&
                (line_cur.cur_x[7:0] < cfg.screen_width) &&
                (line_cur.cur_y[COORD_BITS-1:8] == '0) &&
                (line_cur.cur_y[7:0] < cfg.screen_height);
    row_base = line_cur.cur_y[7:0] * cfg.screen_width;

    res.point_active  = 1'b1;
    res.write_enable  = on_screen;
    res.pixel_address = on_screen ? row_base + {8'd0, line_cur.cur_x[7:0]} : 16'd0;
    res.pixel_color   = on_screen ? color : 16'd0;
    res.line_done     = done;

    // Bresenham step
    e_w    = {line_cur.error_term[ERR_W-1], line_cur.error_term};
    sx_w   = $signed({2'b00, line_cur.span_x});
    sy_w   = $signed({2'b00, line_cur.span_y});
    move_x = e_w > -sx_w;
    move_y = e_w < sy_w;
    e_n    = e_w - (move_x ? sy_w : '0) + (move_y ? sx_w : '0);
    inc_x  = line_cur.step_x_negative ? '1 : coord_t'(1);
    inc_y  = line_cur.step_y_negative ? '1 : coord_t'(1);

    line_next            = line_cur;
    line_next.error_term = e_n[ERR_W-1:0];
    if (move_x) begin
      line_next.cur_x = line_cur.cur_x + inc_x;
    end
    if (move_y) begin
      line_next.cur_y = line_cur.cur_y + inc_y;
    end
  end

endmodule
